>>> hw/rtl/drq_pkg.sv
// shared types, codes and helpers for the descriptor ring queue
`timescale 1ns / 1ps

package drq_pkg;

  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int ADR_W  = 64;
  localparam int QID_W  = 16;
  localparam int CFG_IDX_W = 3;

  // slot storage depth, tied to the 8-bit indices and the 9-bit count
  localparam int RING_DEPTH = 256;

  // operation codes carried in the input kind field
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SIZE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RING_ENTRIES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DESC_BYTES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_NUMBER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RING_BASE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_MODE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DOORBELL_ON  = 3'd5;

  typedef struct packed {
    logic [CNT_W-1:0] ring_entries;
    logic [LEN_W-1:0] desc_bytes;
    logic [QID_W-1:0] queue_number;
    logic [ADR_W-1:0] ring_base;
    logic             host_mode;
    logic             doorbell_on;
  } cfg_t;

  // storage request for one accepted item
  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [IDX_W-1:0] slot;
  } mem_req_t;

  // result fields known at the decision point (pop data joins later)
  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] moved_bytes;
    logic [ADR_W-1:0] slot_host_address;
    logic             bell_valid;
    logic [QID_W-1:0] bell_queue;
    logic [IDX_W-1:0] bell_index;
    logic [CNT_W-1:0] fill_level;
    logic [CNT_W-1:0] free_slots;
  } result_t;

  // keeps the low nbytes bytes of a descriptor word
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] nbytes);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      m[b*8 +: 8] = (LEN_W'(b) < nbytes) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/drq_store.sv
// descriptor slot memory, one write or one registered read per cycle
`timescale 1ns / 1ps

module drq_store
  import drq_pkg::*;
#(
  parameter int MAX_DESC_BYTES = 8
) (
  input  logic              clk,
  input  mem_req_t          req,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int WORD_W = MAX_DESC_BYTES * 8;

  logic [WORD_W-1:0] mem [RING_DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] addr;

  // indices always stay below the clamped ring size, so no wrap is needed here
  assign addr = ADDR_W'(req.slot);

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[addr] <= wr_data[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = DATA_W'(rd_data_r);

endmodule

>>> hw/rtl/drq_ctrl.sv
// producer/consumer indices, fill count and per-item decision
`timescale 1ns / 1ps

module drq_ctrl
  import drq_pkg::*;
#(
  parameter int MAX_DESC_BYTES = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_fire,
  input  logic [1:0]       kind,
  input  logic [LEN_W-1:0] length_bytes,
  output mem_req_t         req,
  output result_t          res
);

  localparam int CLAMP = (RING_DEPTH > 511) ? 511 : RING_DEPTH;
  localparam logic [LEN_W-1:0] MAXB = LEN_W'(MAX_DESC_BYTES);

  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] eff;
  logic             size_ok;
  logic [IDX_W-1:0] wr_adv, rd_adv;
  logic [IDX_W-1:0] slot;
  logic [11:0]      offset;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] n;
    n = {1'b0, idx} + CNT_W'(1);
    if (n >= lim) n = '0;
    return n[IDX_W-1:0];
  endfunction

  always_comb begin
    if (cfg.ring_entries == '0) begin
      eff = CNT_W'(1);
    end else if (cfg.ring_entries > CNT_W'(CLAMP)) begin
      eff = CNT_W'(CLAMP);
    end else begin
      eff = cfg.ring_entries;
    end
  end

  assign size_ok = (cfg.desc_bytes != '0) && (cfg.desc_bytes <= MAXB) &&
                   (length_bytes == cfg.desc_bytes);
  assign wr_adv  = advance(wr_idx_r, eff);
  assign rd_adv  = advance(rd_idx_r, eff);
  assign slot    = (kind == KIND_POP) ? rd_idx_r : wr_idx_r;
  assign offset  = 12'(slot) * 12'(cfg.desc_bytes);

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    cnt_nxt    = cnt_r;
    req        = '0;
    req.slot   = slot;
    res        = '0;
    case (kind)
      KIND_PUSH: begin
        if (!size_ok) begin
          res.status = ST_SIZE;
        end else if (cnt_r >= eff) begin
          res.status = ST_FULL;
        end else begin
          res.slot_host_address = cfg.ring_base + ADR_W'(offset);
          res.moved_bytes       = cfg.desc_bytes;
          req.wr                = !cfg.host_mode;
          wr_idx_nxt            = wr_adv;
          cnt_nxt               = cnt_r + CNT_W'(1);
          if (cfg.doorbell_on) begin
            res.bell_valid = 1'b1;
            res.bell_queue = cfg.queue_number;
            res.bell_index = wr_adv;
          end
        end
      end
      KIND_POP: begin
        if (!size_ok) begin
          res.status = ST_SIZE;
        end else if (cnt_r == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.slot_host_address = cfg.ring_base + ADR_W'(offset);
          res.moved_bytes       = cfg.desc_bytes;
          req.rd                = !cfg.host_mode;
          rd_idx_nxt            = rd_adv;
          cnt_nxt               = cnt_r - CNT_W'(1);
        end
      end
      KIND_CLEAR: begin
        wr_idx_nxt = '0;
        rd_idx_nxt = '0;
        cnt_nxt    = '0;
      end
      default: begin
      end
    endcase
    res.fill_level = cnt_nxt;
    res.free_slots = (cnt_nxt >= eff) ? '0 : eff - cnt_nxt;
    // storage only moves on an accepted item
    req.wr = req.wr & in_fire;
    req.rd = req.rd & in_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else if (in_fire) begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CLAMP))
    else $error("fill count above ring capacity");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, wr_idx_r} < CNT_W'(CLAMP)) && ({1'b0, rd_idx_r} < CNT_W'(CLAMP)))
    else $error("ring index beyond storage");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && kind == KIND_PUSH && res.status == ST_OK)
    |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("successful push did not raise the fill count");
`endif

endmodule

>>> hw/rtl/descriptor_ring_queue.sv
// top level of the descriptor ring queue: config registers, pipeline and ports
`timescale 1ns / 1ps

// usage
// - in_ channel: one transfer per operation; in_tuser is the kind (push, pop,
//   clear indices), in_tdata holds the length and the descriptor to push
// - out_ channel: exactly one result transfer per accepted operation, in order;
//   out_tuser is the status, out_tdata the remaining result fields
// - cfg_ channel: register writes, always ready; write only while no operation
//   is in flight; indexes past the last register are ignored
// - a result passes the decision/memory-read stage, then the output register
// - throughput: one operation per cycle unless out_tready holds results back;
//   index and count updates are single increments with wrap, and the slot
//   memory does one write or one read per item
// - a stalled receiver first fills the output register, then the memory-read
//   stage, then in_tready drops; nothing is lost or repeated
// - reset (rst_n low, synchronous) clears indices, count and the pipeline and
//   restores register defaults; slot contents are undefined until pushed
module descriptor_ring_queue
  import drq_pkg::*;
#(
  parameter int MAX_DESC_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [71:0]          in_tdata,   // length_bytes[3:0], push_data[67:4], zero pad
  input  logic [1:0]           in_tuser,   // kind[1:0]

  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [175:0]         out_tdata,  // moved_bytes[3:0], pop_data[67:4],
                                           // slot_host_address[131:68], bell_valid[132],
                                           // bell_queue[148:133], bell_index[156:149],
                                           // fill_level[165:157], free_slots[174:166], pad
  output logic [1:0]           out_tuser,  // status[1:0]

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  cfg_t              cfg_r;
  logic              in_fire;
  logic              s1_adv;
  mem_req_t          req;
  result_t           res;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] wr_data;

  logic              s1_v_r;
  result_t           s1_res_r;
  logic              s1_rd_r;

  logic              out_v_r;
  result_t           out_res_r;
  logic [DATA_W-1:0] out_pop_r;

  // register bank, writes always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_entries <= CNT_W'(256);
      cfg_r.desc_bytes   <= LEN_W'(8);
      cfg_r.queue_number <= '0;
      cfg_r.ring_base    <= '0;
      cfg_r.host_mode    <= 1'b0;
      cfg_r.doorbell_on  <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RING_ENTRIES: cfg_r.ring_entries <= cfg_data[CNT_W-1:0];
        REG_DESC_BYTES:   cfg_r.desc_bytes   <= cfg_data[LEN_W-1:0];
        REG_QUEUE_NUMBER: cfg_r.queue_number <= cfg_data[QID_W-1:0];
        REG_RING_BASE:    cfg_r.ring_base    <= cfg_data;
        REG_HOST_MODE:    cfg_r.host_mode    <= cfg_data[0];
        REG_DOORBELL_ON:  cfg_r.doorbell_on  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // stage handshakes: output register, then decision/memory stage
  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  // only the low desc_bytes bytes of a pushed descriptor are kept
  assign wr_data = in_tdata[67:4] & byte_mask(cfg_r.desc_bytes);

  drq_ctrl #(
    .MAX_DESC_BYTES (MAX_DESC_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_fire      (in_fire),
    .kind         (in_tuser),
    .length_bytes (in_tdata[3:0]),
    .req          (req),
    .res          (res)
  );

  drq_store #(
    .MAX_DESC_BYTES (MAX_DESC_BYTES)
  ) u_store (
    .clk     (clk),
    .req     (req),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // decision stage, waits here for the slot read to land
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_res_r <= res;
      s1_rd_r  <= req.rd;
    end
  end

  // output register; read data is held by the store while this stage stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_adv) begin
      out_res_r <= s1_res_r;
      out_pop_r <= s1_rd_r ? (rd_data & byte_mask(cfg_r.desc_bytes)) : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {1'b0,
                       out_res_r.free_slots,
                       out_res_r.fill_level,
                       out_res_r.bell_index,
                       out_res_r.bell_queue,
                       out_res_r.bell_valid,
                       out_res_r.slot_host_address,
                       out_pop_r,
                       out_res_r.moved_bytes};

`ifndef SYNTHESIS
  a_err_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[3:0] == '0 && out_tdata[132] == 1'b0))
    else $error("failed operation reports a transfer or doorbell");

  a_bell_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[132]) |-> (out_tuser == ST_OK && out_tdata[67:4] == '0))
    else $error("doorbell on a result that is not a successful push");

  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_rd_r && !s1_adv) |=> $stable(rd_data))
    else $error("slot read data lost while the pipeline stalled");
`endif

endmodule

>>> dv/testbench.sv
// self-checking testbench for the descriptor ring queue
`timescale 1ns / 1ps

module testbench;
  import drq_pkg::*;

  localparam int RING_SLOTS = 256;
  localparam int DESC_MAX   = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOW_MAX    = 10;

  // kind code outside the defined operations, answered without any change
  localparam logic [1:0] KIND_UNDEFINED = 2'd3;
  // register indexes past the last register, ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // one result as it leaves the block
  typedef struct packed {
    logic [1:0]        status;
    logic [LEN_W-1:0]  moved_bytes;
    logic [DATA_W-1:0] pop_data;
    logic [ADR_W-1:0]  slot_host_address;
    logic              bell_valid;
    logic [QID_W-1:0]  bell_queue;
    logic [IDX_W-1:0]  bell_index;
    logic [CNT_W-1:0]  fill_level;
    logic [CNT_W-1:0]  free_slots;
  } ring_reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [71:0]          in_tdata = '0;   // length_bytes[3:0], push_data[67:4], zero pad
  logic [1:0]           in_tuser = '0;   // kind[1:0]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [175:0]         out_tdata;       // moved_bytes, pop_data, slot_host_address,
                                         // bell_valid, bell_queue, bell_index,
                                         // fill_level, free_slots, pad
  logic [1:0]           out_tuser;       // status[1:0]
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  descriptor_ring_queue #(
    .MAX_DESC_BYTES (DESC_MAX)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow of the ring: registers, slot contents, indices and count
  // ---------------------------------------------------------------------------
  cfg_t             ring_cfg;
  logic [63:0]      slot_mem [RING_SLOTS];
  bit               slot_written [RING_SLOTS];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] held;

  ring_reply_t ring_expect [$];   // replies still owed by the block, oldest first

  bit          idle_on = 1'b1;    // random gaps and stalls allowed
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned replies_seen = 0;
  int unsigned ops_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned bells_seen = 0;
  int unsigned status_seen [4];

  // ring entries as the block uses them: 0 acts as 1, large values clip
  function automatic logic [CNT_W-1:0] live_entries();
    if (ring_cfg.ring_entries == '0) return CNT_W'(1);
    if (ring_cfg.ring_entries > RING_SLOTS) return CNT_W'(RING_SLOTS);
    return ring_cfg.ring_entries;
  endfunction

  function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] idx);
    logic [CNT_W-1:0] n;
    n = {1'b0, idx} + CNT_W'(1);
    if (n >= live_entries()) n = '0;
    return n[IDX_W-1:0];
  endfunction

  function automatic logic [63:0] keep_bytes(logic [LEN_W-1:0] n);
    if (n >= 8) return '1;
    return (64'd1 << (n * 8)) - 64'd1;
  endfunction

  // length must equal a descriptor size that the block supports
  function automatic bit size_fits(logic [LEN_W-1:0] len);
    return ring_cfg.desc_bytes >= 1 && ring_cfg.desc_bytes <= DESC_MAX &&
           len == ring_cfg.desc_bytes;
  endfunction

  // a local pop of a slot never written lies outside the contract
  function automatic bit reads_blank_slot(logic [LEN_W-1:0] len);
    return size_fits(len) && held != '0 && !ring_cfg.host_mode && !slot_written[rd_ptr];
  endfunction

  // applies one operation to the shadow ring and returns the reply it causes
  function automatic ring_reply_t ring_step(logic [1:0] kind, logic [LEN_W-1:0] len,
                                            logic [63:0] data);
    ring_reply_t r;
    logic [CNT_W-1:0] live;
    r = '0;
    r.status = ST_OK;
    live = live_entries();
    case (kind)
      KIND_PUSH: begin
        if (!size_fits(len)) begin
          r.status = ST_SIZE;
        end else if (held >= live) begin
          r.status = ST_FULL;
        end else begin
          r.slot_host_address = ring_cfg.ring_base + 64'(wr_ptr) * 64'(ring_cfg.desc_bytes);
          if (!ring_cfg.host_mode) begin
            slot_mem[wr_ptr] = data & keep_bytes(ring_cfg.desc_bytes);
            slot_written[wr_ptr] = 1'b1;
          end
          wr_ptr = next_slot(wr_ptr);
          held = held + CNT_W'(1);
          r.moved_bytes = ring_cfg.desc_bytes;
          if (ring_cfg.doorbell_on) begin
            r.bell_valid = 1'b1;
            r.bell_queue = ring_cfg.queue_number;
            r.bell_index = wr_ptr;
          end
        end
      end
      KIND_POP: begin
        if (!size_fits(len)) begin
          r.status = ST_SIZE;
        end else if (held == '0) begin
          r.status = ST_EMPTY;
        end else begin
          r.slot_host_address = ring_cfg.ring_base + 64'(rd_ptr) * 64'(ring_cfg.desc_bytes);
          if (!ring_cfg.host_mode) r.pop_data = slot_mem[rd_ptr] & keep_bytes(ring_cfg.desc_bytes);
          rd_ptr = next_slot(rd_ptr);
          held = held - CNT_W'(1);
          r.moved_bytes = ring_cfg.desc_bytes;
        end
      end
      KIND_CLEAR: begin
        wr_ptr = '0;
        rd_ptr = '0;
        held = '0;
      end
      default: ;
    endcase
    r.fill_level = held;
    r.free_slots = (held >= live) ? '0 : live - held;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall bursts and the checker
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (idle_on && stall_left == 0 && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 16);
    if (!idle_on) stall_left = 0;
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void match_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= SHOW_MAX)
        $display("mismatch on reply %0d, %s: expected %h, got %h",
                 replies_seen, name, want, got);
    end
  endfunction

  task automatic check_reply();
    ring_reply_t want;
    ring_reply_t got;
    got.status            = out_tuser;
    got.moved_bytes       = out_tdata[3:0];
    got.pop_data          = out_tdata[67:4];
    got.slot_host_address = out_tdata[131:68];
    got.bell_valid        = out_tdata[132];
    got.bell_queue        = out_tdata[148:133];
    got.bell_index        = out_tdata[156:149];
    got.fill_level        = out_tdata[165:157];
    got.free_slots        = out_tdata[174:166];
    replies_seen++;
    if (ring_expect.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOW_MAX)
        $display("reply %0d arrived with none outstanding", replies_seen);
    end else begin
      want = ring_expect.pop_front();
      match_field("status", 64'(want.status), 64'(got.status));
      match_field("moved_bytes", 64'(want.moved_bytes), 64'(got.moved_bytes));
      match_field("pop_data", want.pop_data, got.pop_data);
      match_field("slot_host_address", want.slot_host_address, got.slot_host_address);
      match_field("bell_valid", 64'(want.bell_valid), 64'(got.bell_valid));
      match_field("bell_queue", 64'(want.bell_queue), 64'(got.bell_queue));
      match_field("bell_index", 64'(want.bell_index), 64'(got.bell_index));
      match_field("fill_level", 64'(want.fill_level), 64'(got.fill_level));
      match_field("free_slots", 64'(want.free_slots), 64'(got.free_slots));
    end
    status_seen[got.status]++;
    if (got.bell_valid === 1'b1) bells_seen++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_reply();
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // one operation transfer, with an optional idle burst in front of it
  task automatic send_op(logic [1:0] kind, logic [LEN_W-1:0] len, logic [63:0] data);
    int unsigned gap;
    if (kind == KIND_POP && reads_blank_slot(len)) kind = KIND_CLEAR;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'h0, data, len};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ring_expect.push_back(ring_step(kind, len, data));
    ops_sent++;
    @(negedge clk);
  endtask

  // register write, only once the pipeline has emptied
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    in_tvalid <= 1'b0;
    while (ring_expect.size() != 0) @(negedge clk);
    // last reply is out, allow the two-stage pipeline to settle
    repeat (3) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RING_ENTRIES: ring_cfg.ring_entries = value[CNT_W-1:0];
      REG_DESC_BYTES:   ring_cfg.desc_bytes   = value[LEN_W-1:0];
      REG_QUEUE_NUMBER: ring_cfg.queue_number = value[QID_W-1:0];
      REG_RING_BASE:    ring_cfg.ring_base    = value;
      REG_HOST_MODE:    ring_cfg.host_mode    = value[0];
      REG_DOORBELL_ON:  ring_cfg.doorbell_on  = value[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup_ring(int entries, int nbytes, int qid, logic [63:0] base,
                            bit host, bit bell);
    write_reg(REG_RING_ENTRIES, 64'(entries));
    write_reg(REG_DESC_BYTES, 64'(nbytes));
    write_reg(REG_QUEUE_NUMBER, 64'(qid));
    write_reg(REG_RING_BASE, base);
    write_reg(REG_HOST_MODE, 64'(host));
    write_reg(REG_DOORBELL_ON, 64'(bell));
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // pushes until one past full, then pops until one past empty
  task automatic fill_and_drain(int depth);
    for (int i = 0; i <= depth; i++) send_op(KIND_PUSH, ring_cfg.desc_bytes, rand_word());
    for (int i = 0; i <= depth; i++) send_op(KIND_POP, ring_cfg.desc_bytes, rand_word());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset defaults: every operation, size check before empty, unknown kind, clear
  task automatic test_basic_ops();
    send_op(KIND_POP, 4'd8, '0);
    send_op(KIND_POP, 4'd7, '0);
    send_op(KIND_PUSH, 4'd0, '1);
    send_op(KIND_PUSH, 4'd15, '1);
    send_op(KIND_PUSH, 4'd8, '1);
    send_op(KIND_PUSH, 4'd8, '0);
    send_op(KIND_PUSH, 4'd8, 64'h0123_4567_89AB_CDEF);
    send_op(KIND_UNDEFINED, 4'd8, '1);
    send_op(KIND_POP, 4'd8, '1);
    send_op(KIND_POP, 4'd8, '0);
    send_op(KIND_POP, 4'd8, rand_word());
    send_op(KIND_POP, 4'd8, rand_word());
    send_op(KIND_PUSH, 4'd8, rand_word());
    send_op(KIND_CLEAR, 4'd15, '1);
    send_op(KIND_POP, 4'd8, '0);
  endtask

  // full and empty at the extremes of ring size, stride, base and the modes
  task automatic test_ring_extremes();
    setup_ring(1, 1, 16'hFFFF, '1, 1'b0, 1'b1);
    fill_and_drain(1);
    fill_and_drain(1);
    setup_ring(0, 8, 16'h0001, 64'hFFFF_FFFF_FFFF_FFF8, 1'b0, 1'b1);
    fill_and_drain(1);
    setup_ring(2, 5, 0, '0, 1'b0, 1'b1);
    fill_and_drain(2);
    fill_and_drain(2);
    // oversize entries clip to the full depth; base chosen so addresses wrap
    setup_ring(511, 8, 16'hA5A5, 64'hFFFF_FFFF_FFFF_FC00, 1'b0, 1'b1);
    fill_and_drain(RING_SLOTS);
    // host-backed ring with the doorbell off
    setup_ring(5, 3, 16'h1234, {$urandom, $urandom}, 1'b1, 1'b0);
    fill_and_drain(5);
    write_reg(REG_HOST_MODE, 64'd0);
    write_reg(REG_DOORBELL_ON, 64'd1);
    send_op(KIND_CLEAR, 4'd0, '0);
  endtask

  // unsupported descriptor sizes and writes to unused register indexes
  task automatic test_bad_sizes();
    write_reg(REG_DESC_BYTES, 64'd0);
    send_op(KIND_PUSH, 4'd0, rand_word());
    send_op(KIND_POP, 4'd0, '0);
    send_op(KIND_PUSH, 4'd8, rand_word());
    write_reg(REG_DESC_BYTES, 64'd9);
    send_op(KIND_PUSH, 4'd9, rand_word());
    send_op(KIND_POP, 4'd9, '0);
    write_reg(REG_DESC_BYTES, 64'd15);
    send_op(KIND_PUSH, 4'd15, rand_word());
    send_op(KIND_POP, 4'd15, '0);
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, '1);
    write_reg(REG_DESC_BYTES, 64'd4);
    send_op(KIND_PUSH, 4'd4, rand_word());
    send_op(KIND_POP, 4'd4, '0);
  endtask

  // ring made smaller than the held count, indices left past the wrap point
  task automatic test_shrunk_ring();
    setup_ring(256, 2, $urandom_range(0, 65535), {$urandom, $urandom}, 1'b0, 1'b1);
    send_op(KIND_CLEAR, 4'd2, '0);
    repeat (10) send_op(KIND_PUSH, 4'd2, rand_word());
    write_reg(REG_RING_ENTRIES, 64'd4);
    send_op(KIND_PUSH, 4'd2, rand_word());
    repeat (7) send_op(KIND_POP, 4'd2, '0);
    repeat (2) send_op(KIND_PUSH, 4'd2, rand_word());
    repeat (5) send_op(KIND_POP, 4'd2, '0);
    fill_and_drain(4);
  endtask

  // random settings per phase, then push/pop traffic with some noise mixed in
  task automatic test_random_traffic(int phases, int per_phase);
    int unsigned push_pct;
    int unsigned pick;
    logic [1:0]  kind;
    logic [LEN_W-1:0] len;
    int          entries;
    int          nbytes;
    logic [63:0] base;
    for (int p = 0; p < phases; p++) begin
      // no idling in the closing phase
      idle_on = (p != phases - 1);
      case ($urandom_range(0, 9))
        0: entries = 0;
        1: entries = $urandom_range(257, 511);
        2: entries = RING_SLOTS;
        3: entries = $urandom_range(17, 255);
        default: entries = $urandom_range(1, 16);
      endcase
      if ($urandom_range(0, 19) == 0)
        nbytes = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
      else nbytes = $urandom_range(1, DESC_MAX);
      base = ($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(0, 255))
                                         : {$urandom, $urandom};
      setup_ring(entries, nbytes, $urandom_range(0, 65535), base,
                 $urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0);
      push_pct = $urandom_range(35, 65);
      for (int i = 0; i < per_phase; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) kind = KIND_CLEAR;
        else if (pick < 6) kind = KIND_UNDEFINED;
        else kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
        len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 15)) : ring_cfg.desc_bytes;
        send_op(kind, len, rand_word());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------
  initial begin
    // shadow state matches the block just after reset
    ring_cfg.ring_entries = CNT_W'(RING_SLOTS);
    ring_cfg.desc_bytes   = LEN_W'(DESC_MAX);
    ring_cfg.queue_number = '0;
    ring_cfg.ring_base    = '0;
    ring_cfg.host_mode    = 1'b0;
    ring_cfg.doorbell_on  = 1'b1;
    wr_ptr = '0;
    rd_ptr = '0;
    held   = '0;
    foreach (slot_written[i]) slot_written[i] = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_ops();
    test_ring_extremes();
    test_bad_sizes();
    test_shrunk_ring();
    test_random_traffic(4, 10);

    // drain every outstanding reply, then watch a little longer for strays
    in_tvalid <= 1'b0;
    while (ring_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("ran %0d operations and %0d register writes over %0d cycles, %0d replies checked",
             ops_sent, reg_writes, cycles, replies_seen);
    $display("status ok %0d, size %0d, full %0d, empty %0d; doorbells %0d; mismatches %0d",
             status_seen[ST_OK], status_seen[ST_SIZE], status_seen[ST_FULL],
             status_seen[ST_EMPTY], bells_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
